@@ rtl/ottd_pkg.sv @@
// shared types and constants for the outstanding transaction table
`default_nettype none
package ottd_pkg;

    localparam int SLOT_COUNT_DEF = 256;
    localparam logic [8:0] COUNT_MAX = 9'd511;

    typedef enum logic [1:0] {
        CMD_BEGIN    = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_POLL     = 2'd2,
        CMD_LOOKUP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_FULL = 2'd2,
        STAT_MISS = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [63:0] txn_key;
        logic [4:0]  peer_core;
        logic [7:0]  message_kind;
        logic [63:0] due_tick;
        logic [63:0] current_tick;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [8:0]  expired_count;
        logic [4:0]  hit_peer_core;
        logic [7:0]  hit_message_kind;
        logic [63:0] hit_due_tick;
    } t_result;

    // one stored transaction
    typedef struct packed {
        logic [63:0] key;
        logic [4:0]  peer;
        logic [7:0]  kind;
        logic [63:0] due;
    } t_entry;

endpackage
`default_nettype wire

@@ rtl/outstanding_txn_table_with_deadline_unit.sv @@
// Outstanding transaction table: each command scans every slot, one slot read per cycle
// from the entry and live-mark memories; busy is high while the command runs, up to the
// result strobe. After reset a clearing pass writes every live mark to zero with busy
// high. The result is registered onto o_result with o_strobe high for exactly one cycle;
// o_result then holds it until the next command finishes. The strobe cannot be held
// off by the receiver.
`default_nettype none
module outstanding_txn_table_with_deadline_unit #(
    parameter int SLOT_COUNT = ottd_pkg::SLOT_COUNT_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  ottd_pkg::t_item     i_item,
    output logic                o_strobe,
    output ottd_pkg::t_result   o_result
);

    localparam int ADDR_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = ADDR_W + 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_COUNT);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    // control
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_chk_valid, n_chk_valid;
    logic             r_found, n_found;
    logic             r_free_found, n_free_found;
    logic             r_strobe, n_strobe;

    // payload
    ottd_pkg::t_item   r_item, n_item;
    logic [ADDR_W-1:0] r_chk_addr, n_chk_addr;
    logic [ADDR_W-1:0] r_hit_idx, n_hit_idx;
    logic [ADDR_W-1:0] r_free_idx, n_free_idx;
    ottd_pkg::t_entry  r_hit, n_hit;
    logic [8:0]        r_count, n_count;
    ottd_pkg::t_result r_result, n_result;

    // memory side
    logic              mem_live;
    ottd_pkg::t_entry  mem_entry;
    logic              live_we, live_wdata, ent_we;
    logic [ADDR_W-1:0] live_waddr;
    ottd_pkg::t_entry  ent_wdata;
    logic              key_match;

    ottd_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_addr    (r_issue[ADDR_W-1:0]),
        .o_live       (mem_live),
        .o_entry      (mem_entry),
        .i_live_we    (live_we),
        .i_live_waddr (live_waddr),
        .i_live_wdata (live_wdata),
        .i_ent_we     (ent_we),
        .i_ent_waddr  (r_free_idx),
        .i_ent_wdata  (ent_wdata)
    );

    assign key_match = mem_live && (mem_entry.key == r_item.txn_key);

    always_comb begin
        n_state      = r_state;
        n_issue      = r_issue;
        n_chk_valid  = 1'b0;
        n_found      = r_found;
        n_free_found = r_free_found;
        n_strobe     = 1'b0;
        n_item       = r_item;
        n_chk_addr   = r_chk_addr;
        n_hit_idx    = r_hit_idx;
        n_free_idx   = r_free_idx;
        n_hit        = r_hit;
        n_count      = r_count;
        n_result     = r_result;
        live_we      = 1'b0;
        live_waddr   = r_chk_addr;
        live_wdata   = 1'b0;
        ent_we       = 1'b0;
        ent_wdata    = '{key: r_item.txn_key, peer: r_item.peer_core,
                         kind: r_item.message_kind, due: r_item.due_tick};

        case (r_state)
            ST_CLEAR: begin
                live_we    = 1'b1;
                live_waddr = r_issue[ADDR_W-1:0];
                if (r_issue == LAST_CNT - CNT_W'(1)) begin
                    n_issue = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_issue = r_issue + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_item       = i_item;
                    n_issue      = '0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_count      = '0;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, check the slot read the cycle before
                if (r_issue != LAST_CNT) begin
                    n_chk_valid = 1'b1;
                    n_chk_addr  = r_issue[ADDR_W-1:0];
                    n_issue     = r_issue + CNT_W'(1);
                end else if (!r_chk_valid) begin
                    n_state = ST_FINISH;
                end
                if (r_chk_valid) begin
                    if (key_match && !r_found) begin
                        n_found   = 1'b1;
                        n_hit_idx = r_chk_addr;
                        n_hit     = mem_entry;
                    end
                    if (!mem_live && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_chk_addr;
                    end
                    if (r_item.cmd == ottd_pkg::CMD_POLL && mem_live
                            && r_item.current_tick >= mem_entry.due) begin
                        live_we = 1'b1;
                        if (r_count != ottd_pkg::COUNT_MAX) begin
                            n_count = r_count + 9'd1;
                        end
                    end
                end
            end
            ST_FINISH: begin
                n_result = '{status: ottd_pkg::STAT_OK, expired_count: 9'd0,
                             hit_peer_core: 5'd0, hit_message_kind: 8'd0,
                             hit_due_tick: 64'd0};
                case (r_item.cmd)
                    ottd_pkg::CMD_BEGIN: begin
                        if (r_found) begin
                            n_result.status = ottd_pkg::STAT_DUP;
                        end else if (r_free_found) begin
                            ent_we     = 1'b1;
                            live_we    = 1'b1;
                            live_waddr = r_free_idx;
                            live_wdata = 1'b1;
                        end else begin
                            n_result.status = ottd_pkg::STAT_FULL;
                        end
                    end
                    ottd_pkg::CMD_COMPLETE: begin
                        if (r_found) begin
                            live_we    = 1'b1;
                            live_waddr = r_hit_idx;
                        end else begin
                            n_result.status = ottd_pkg::STAT_MISS;
                        end
                    end
                    ottd_pkg::CMD_POLL: begin
                        n_result.expired_count = r_count;
                    end
                    default: begin
                        if (r_found) begin
                            n_result.hit_peer_core    = r_hit.peer;
                            n_result.hit_message_kind = r_hit.kind;
                            n_result.hit_due_tick     = r_hit.due;
                        end else begin
                            n_result.status = ottd_pkg::STAT_MISS;
                        end
                    end
                endcase
                n_strobe = 1'b1;
                n_issue  = '0;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_issue      <= '0;
            r_chk_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue      <= n_issue;
            r_chk_valid  <= n_chk_valid;
            r_found      <= n_found;
            r_free_found <= n_free_found;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_chk_addr <= n_chk_addr;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_hit      <= n_hit;
        r_count    <= n_count;
        r_result   <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

@@ rtl/ottd_store.sv @@
// live-mark memory and entry memory, registered read at a shared address
`default_nettype none
module ottd_store #(
    parameter int SLOT_COUNT = ottd_pkg::SLOT_COUNT_DEF,
    localparam int ADDR_W = $clog2(SLOT_COUNT)
) (
    input  wire                  i_clk,
    input  wire [ADDR_W-1:0]     i_rd_addr,
    output logic                 o_live,
    output ottd_pkg::t_entry     o_entry,
    input  wire                  i_live_we,
    input  wire [ADDR_W-1:0]     i_live_waddr,
    input  wire                  i_live_wdata,
    input  wire                  i_ent_we,
    input  wire [ADDR_W-1:0]     i_ent_waddr,
    input  ottd_pkg::t_entry     i_ent_wdata
);

    logic             r_live_mem [SLOT_COUNT];
    ottd_pkg::t_entry r_ent_mem  [SLOT_COUNT];
    logic             r_live_q;
    ottd_pkg::t_entry r_ent_q;

    always_ff @(posedge i_clk) begin
        if (i_live_we) begin
            r_live_mem[i_live_waddr] <= i_live_wdata;
        end
        r_live_q <= r_live_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_ent_mem[i_ent_waddr] <= i_ent_wdata;
        end
        r_ent_q <= r_ent_mem[i_rd_addr];
    end

    assign o_live  = r_live_q;
    assign o_entry = r_ent_q;

endmodule
`default_nettype wire
